/* rtl/integer_literal_parser_core_macros.svh */
// Assertion macros for the integer literal parser core.
// Used by the top level; needs i_clk and i_rst_n in the including scope.
`ifndef INTEGER_LITERAL_PARSER_CORE_MACROS_SVH
`define INTEGER_LITERAL_PARSER_CORE_MACROS_SVH

// check a property every clock outside reset
`define ILP_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) else $error(msg);

// check that a condition holds in the cycle after a trigger
`define ILP_ASSERT_NEXT(lbl, trig, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (trig) |=> (cons)) \
        else $error(msg);

`endif

/* rtl/ilp_pkg.sv */
// Shared types, codes and character helpers for the integer literal parser.
// No dependencies; used by ilp_scan and integer_literal_parser_core.
package ilp_pkg;

    localparam int TDATA_W = 80;

    // literal kinds
    localparam logic [2:0] KIND_DEC  = 3'd0;
    localparam logic [2:0] KIND_HEX  = 3'd1;
    localparam logic [2:0] KIND_OCT  = 3'd2;
    localparam logic [2:0] KIND_BIN  = 3'd3;
    localparam logic [2:0] KIND_CHAR = 3'd4;

    // error codes
    localparam logic [2:0] ERR_OK       = 3'd0;
    localparam logic [2:0] ERR_EXPECTED = 3'd1;
    localparam logic [2:0] ERR_INVALID  = 3'd2;
    localparam logic [2:0] ERR_RANGE    = 3'd3;
    localparam logic [2:0] ERR_BADCHAR  = 3'd4;

    // register indexes
    localparam logic REG_VALUE_TYPE = 1'b0;
    localparam logic [2:0] VALUE_TYPE_RST = 3'd5;

    // characters
    localparam logic [7:0] CH_PLUS   = 8'h2b;
    localparam logic [7:0] CH_MINUS  = 8'h2d;
    localparam logic [7:0] CH_QUOTE  = 8'h27;
    localparam logic [7:0] CH_DQUOTE = 8'h22;
    localparam logic [7:0] CH_BSLASH = 8'h5c;
    localparam logic [7:0] CH_QMARK  = 8'h3f;
    localparam logic [7:0] CH_UNDER  = 8'h5f;
    localparam logic [7:0] CH_0      = 8'h30;
    localparam logic [7:0] CH_1      = 8'h31;
    localparam logic [7:0] CH_9      = 8'h39;
    localparam logic [7:0] CH_LA     = 8'h61;
    localparam logic [7:0] CH_LF     = 8'h66;
    localparam logic [7:0] CH_UA     = 8'h41;
    localparam logic [7:0] CH_UF     = 8'h46;
    localparam logic [7:0] CH_LX     = 8'h78;
    localparam logic [7:0] CH_UX     = 8'h58;
    localparam logic [7:0] CH_LO     = 8'h6f;
    localparam logic [7:0] CH_UO     = 8'h4f;
    localparam logic [7:0] CH_LB     = 8'h62;
    localparam logic [7:0] CH_UB     = 8'h42;
    localparam logic [7:0] CH_PRT_LO = 8'h20;
    localparam logic [7:0] CH_PRT_HI = 8'h7e;

    // finished token handed from the scanner to the output stage
    typedef struct packed {
        logic [63:0] mag;
        logic        ovf;
        logic        neg;
        logic        chk;
        logic        fail;
        logic [2:0]  err;
        logic [2:0]  kind;
        logic [6:0]  len;
    } t_pend;

    // {valid, digit} of a character in the radix of a literal kind
    function automatic logic [4:0] digit_of(input logic [7:0] c, input logic [2:0] kind);
        logic [3:0] d;
        logic       v;
        d = 4'd0;
        v = 1'b0;
        if (c >= CH_0 && c <= CH_9) begin
            d = 4'(c - CH_0);
            v = 1'b1;
        end else if (c >= CH_LA && c <= CH_LF) begin
            d = 4'(c - CH_LA + 8'd10);
            v = 1'b1;
        end else if (c >= CH_UA && c <= CH_UF) begin
            d = 4'(c - CH_UA + 8'd10);
            v = 1'b1;
        end
        case (kind)
            KIND_HEX: ;
            KIND_OCT: if (d > 4'd7) v = 1'b0;
            KIND_BIN: if (d > 4'd1) v = 1'b0;
            default:  if (d > 4'd9) v = 1'b0;
        endcase
        return {v, d};
    endfunction

    // {valid, byte} of a simple backslash escape
    function automatic logic [8:0] escape_of(input logic [7:0] c);
        logic [8:0] r;
        case (c)
            CH_BSLASH: r = {1'b1, CH_BSLASH};
            CH_QUOTE:  r = {1'b1, CH_QUOTE};
            8'h61:     r = {1'b1, 8'd7};
            8'h62:     r = {1'b1, 8'd8};
            8'h66:     r = {1'b1, 8'd12};
            8'h6e:     r = {1'b1, 8'd10};
            8'h72:     r = {1'b1, 8'd13};
            8'h74:     r = {1'b1, 8'd9};
            8'h76:     r = {1'b1, 8'd11};
            CH_QMARK:  r = {1'b1, CH_QMARK};
            CH_DQUOTE: r = {1'b1, CH_DQUOTE};
            default:   r = 9'd0;
        endcase
        return r;
    endfunction

endpackage

/* rtl/ilp_scan.sv */
// Token scanner: per-character parse state and magnitude accumulation.
// Depends on ilp_pkg; instantiated by integer_literal_parser_core.
module ilp_scan #(
    parameter int MAX_LEN = 64
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_acc,
    input  logic [7:0]     i_char,
    input  logic           i_last,
    input  logic           i_signed,
    output logic           o_res,
    output ilp_pkg::t_pend o_pend
);
    import ilp_pkg::*;

    localparam int CW = $clog2(MAX_LEN + 1);

    localparam logic [3:0] PH_START  = 4'd0;
    localparam logic [3:0] PH_SIGNED = 4'd1;
    localparam logic [3:0] PH_ZERO   = 4'd2;
    localparam logic [3:0] PH_PREFIX = 4'd3;
    localparam logic [3:0] PH_DIGITS = 4'd4;
    localparam logic [3:0] PH_QUOTE  = 4'd5;
    localparam logic [3:0] PH_ESC    = 4'd6;
    localparam logic [3:0] PH_HEX1   = 4'd7;
    localparam logic [3:0] PH_HEX2   = 4'd8;
    localparam logic [3:0] PH_CLOSE  = 4'd9;

    logic [3:0]  r_phase, n_phase;
    logic [63:0] r_mag, n_mag;
    logic        r_ovf, n_ovf;
    logic        r_neg, n_neg;
    logic [2:0]  r_kind, n_kind;
    logic [CW-1:0] r_cnt, n_cnt;
    logic [3:0]  r_nib, n_nib;
    logic        r_done, n_done;

    logic [2:0]  eff_kind;
    logic [4:0]  dig;
    logic [4:0]  hex_dig;
    logic [8:0]  esc;
    logic [67:0] acc_prod;
    logic [67:0] acc_sum;
    logic        acc_ovf;
    logic [CW-1:0] cnt_inc;
    logic        res, fin, chk, fl;
    logic [2:0]  err;

    assign eff_kind = (r_phase == PH_ZERO) ? KIND_DEC : r_kind;
    assign dig      = digit_of(i_char, eff_kind);
    assign hex_dig  = digit_of(i_char, KIND_HEX);
    assign esc      = escape_of(i_char);
    assign cnt_inc  = (r_cnt < CW'(MAX_LEN)) ? r_cnt + CW'(1) : r_cnt;

    always_comb begin
        case (eff_kind)
            KIND_HEX: acc_prod = {r_mag, 4'd0};
            KIND_OCT: acc_prod = {1'b0, r_mag, 3'd0};
            KIND_BIN: acc_prod = {3'd0, r_mag, 1'b0};
            default:  acc_prod = {1'b0, r_mag, 3'd0} + {3'd0, r_mag, 1'b0};
        endcase
    end

    assign acc_sum = acc_prod + 68'(dig[3:0]);
    assign acc_ovf = |acc_sum[67:64];

    always_comb begin
        n_phase = r_phase;
        n_mag   = r_mag;
        n_ovf   = r_ovf;
        n_neg   = r_neg;
        n_kind  = r_kind;
        n_cnt   = r_cnt;
        n_nib   = r_nib;
        n_done  = r_done;
        res     = 1'b0;
        fin     = 1'b0;
        chk     = 1'b0;
        fl      = 1'b0;
        err     = ERR_OK;
        o_pend  = '0;

        if (r_done) begin
            if (i_last) begin
                n_done  = 1'b0;
                n_phase = PH_START;
                n_mag   = '0;
                n_ovf   = 1'b0;
                n_neg   = 1'b0;
                n_kind  = KIND_DEC;
                n_cnt   = '0;
                n_nib   = '0;
            end
        end else begin
            unique case (r_phase)
                PH_START, PH_SIGNED: begin
                    if (r_phase == PH_START && (i_char == CH_PLUS || i_char == CH_MINUS)) begin
                        if (i_char == CH_MINUS && !i_signed) begin
                            fl  = 1'b1;
                            err = ERR_RANGE;
                        end else begin
                            n_neg   = (i_char == CH_MINUS);
                            n_cnt   = cnt_inc;
                            n_phase = PH_SIGNED;
                        end
                    end else if (i_char == CH_QUOTE) begin
                        n_kind  = KIND_CHAR;
                        n_cnt   = cnt_inc;
                        n_phase = PH_QUOTE;
                    end else if (i_char == CH_0) begin
                        n_cnt   = cnt_inc;
                        n_phase = PH_ZERO;
                    end else if (i_char >= CH_1 && i_char <= CH_9) begin
                        n_kind  = KIND_DEC;
                        n_mag   = 64'(i_char - CH_0);
                        n_cnt   = cnt_inc;
                        n_phase = PH_DIGITS;
                    end else begin
                        fl  = 1'b1;
                        err = ERR_INVALID;
                    end
                end
                PH_ZERO, PH_DIGITS: begin
                    if (r_phase == PH_ZERO && (i_char == CH_LX || i_char == CH_UX)) begin
                        n_kind  = KIND_HEX;
                        n_cnt   = cnt_inc;
                        n_phase = PH_PREFIX;
                    end else if (r_phase == PH_ZERO && (i_char == CH_LO || i_char == CH_UO)) begin
                        n_kind  = KIND_OCT;
                        n_cnt   = cnt_inc;
                        n_phase = PH_PREFIX;
                    end else if (r_phase == PH_ZERO && (i_char == CH_LB || i_char == CH_UB)) begin
                        n_kind  = KIND_BIN;
                        n_cnt   = cnt_inc;
                        n_phase = PH_PREFIX;
                    end else begin
                        n_kind  = eff_kind;
                        n_phase = PH_DIGITS;
                        if (dig[4]) begin
                            if (!r_ovf) begin
                                if (acc_ovf) n_ovf = 1'b1;
                                else         n_mag = acc_sum[63:0];
                            end
                            n_cnt = cnt_inc;
                        end else if (i_char == CH_UNDER) begin
                            n_cnt = cnt_inc;
                        end else begin
                            fin = 1'b1;
                            chk = 1'b1;
                        end
                    end
                end
                PH_PREFIX: begin
                    if (!dig[4]) begin
                        fl  = 1'b1;
                        err = ERR_INVALID;
                    end else begin
                        if (!r_ovf) begin
                            if (acc_ovf) n_ovf = 1'b1;
                            else         n_mag = acc_sum[63:0];
                        end
                        n_cnt   = cnt_inc;
                        n_phase = PH_DIGITS;
                    end
                end
                PH_QUOTE: begin
                    if (i_char >= CH_PRT_LO && i_char <= CH_PRT_HI && i_char != CH_QUOTE
                        && i_char != CH_BSLASH) begin
                        n_mag   = 64'(i_char);
                        n_cnt   = cnt_inc;
                        n_phase = PH_CLOSE;
                    end else if (i_char == CH_BSLASH) begin
                        n_cnt   = cnt_inc;
                        n_phase = PH_ESC;
                    end else begin
                        fl  = 1'b1;
                        err = ERR_BADCHAR;
                    end
                end
                PH_ESC: begin
                    if (i_char == CH_LX) begin
                        n_cnt   = cnt_inc;
                        n_phase = PH_HEX1;
                    end else if (esc[8]) begin
                        n_mag   = 64'(esc[7:0]);
                        n_cnt   = cnt_inc;
                        n_phase = PH_CLOSE;
                    end else begin
                        fl  = 1'b1;
                        err = ERR_BADCHAR;
                    end
                end
                PH_HEX1, PH_HEX2: begin
                    if (!hex_dig[4]) begin
                        fl  = 1'b1;
                        err = ERR_BADCHAR;
                    end else begin
                        n_cnt = cnt_inc;
                        if (r_phase == PH_HEX1) begin
                            n_nib   = hex_dig[3:0];
                            n_phase = PH_HEX2;
                        end else begin
                            n_mag   = 64'({r_nib, hex_dig[3:0]});
                            n_phase = PH_CLOSE;
                        end
                    end
                end
                PH_CLOSE: begin
                    if (i_char != CH_QUOTE) begin
                        fl  = 1'b1;
                        err = ERR_BADCHAR;
                    end else begin
                        n_cnt = cnt_inc;
                        fin   = 1'b1;
                    end
                end
                default: begin
                    fl  = 1'b1;
                    err = ERR_INVALID;
                end
            endcase

            // token ends with no terminating character seen
            if (!fin && !fl && i_last) begin
                unique case (n_phase)
                    PH_ZERO: begin
                        n_kind = KIND_DEC;
                        fin    = 1'b1;
                        chk    = 1'b1;
                    end
                    PH_DIGITS: begin
                        fin = 1'b1;
                        chk = 1'b1;
                    end
                    PH_QUOTE, PH_ESC, PH_HEX1, PH_HEX2, PH_CLOSE: begin
                        fl  = 1'b1;
                        err = ERR_BADCHAR;
                    end
                    default: begin
                        fl  = 1'b1;
                        err = ERR_INVALID;
                    end
                endcase
            end

            res         = fin || fl;
            o_pend.mag  = n_mag;
            o_pend.ovf  = n_ovf;
            o_pend.neg  = n_neg;
            o_pend.chk  = chk;
            o_pend.fail = fl;
            o_pend.err  = err;
            o_pend.kind = n_kind;
            o_pend.len  = 7'(n_cnt);

            if (res) begin
                n_done  = !i_last;
                n_phase = PH_START;
                n_mag   = '0;
                n_ovf   = 1'b0;
                n_neg   = 1'b0;
                n_kind  = KIND_DEC;
                n_cnt   = '0;
                n_nib   = '0;
            end
        end
    end

    assign o_res = res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_START;
            r_mag   <= '0;
            r_ovf   <= 1'b0;
            r_neg   <= 1'b0;
            r_kind  <= KIND_DEC;
            r_cnt   <= '0;
            r_nib   <= '0;
            r_done  <= 1'b0;
        end else if (i_acc) begin
            r_phase <= n_phase;
            r_mag   <= n_mag;
            r_ovf   <= n_ovf;
            r_neg   <= n_neg;
            r_kind  <= n_kind;
            r_cnt   <= n_cnt;
            r_nib   <= n_nib;
            r_done  <= n_done;
        end
    end

endmodule

/* rtl/integer_literal_parser_core.sv */
// Integer literal parser top level: stream ports, value_type register, output stage.
// Depends on ilp_pkg, ilp_scan and integer_literal_parser_core_macros.svh.
//
// Usage: a token enters one character per request on the s_axis channel
// (tdata = character byte, tlast = last character of the token). One result
// per token leaves on m_axis when the literal ends: at the first character
// that is not part of it, or at the character marked tlast. Characters after
// a finished literal up to tlast give no result.
// value_type (APB, address 0) selects the target type; write it only while
// the block is idle. pready is always high.
// Throughput: one character per cycle while s_axis_tready is high. The result
// for the character that ends the literal is registered in the pending stage,
// then the range check and sign conversion go into the output register.
// Reset clears the token state, value_type goes to 5 (s32), both stages empty.
// When m_axis_tready is low the result holds in the output register, one more
// result waits in the pending stage, and s_axis_tready drops while the pending
// stage is full and cannot advance.
`include "integer_literal_parser_core_macros.svh"

module integer_literal_parser_core #(
    parameter int MAX_LEN = 64
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // stream in
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] char_code
    input  logic        s_axis_tlast,   // is_last
    // stream out
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [ilp_pkg::TDATA_W-1:0] m_axis_tdata, // [63:0] value_bits,
                                                      // [70:64] consumed_length,
                                                      // [73:71] error_code, rest 0
    output logic [2:0]  m_axis_tuser,   // [2:0] literal_kind
    // configuration
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import ilp_pkg::*;

    logic [2:0]  r_vtype;
    logic        reg_idx;
    logic        s_acc;
    logic        scan_res;
    t_pend       scan_pend;

    logic        r_pv, n_pv;
    t_pend       r_pend;
    logic        p_move;

    logic        r_ov, n_ov;
    logic [63:0] r_value;
    logic [2:0]  r_kind;
    logic [6:0]  r_len;
    logic [2:0]  r_err;

    logic [63:0] mask;
    logic [63:0] tmax;
    logic        range_bad;
    logic [63:0] n_value;
    logic [6:0]  n_len;
    logic [2:0]  n_err;

    logic        err_clean;
    logic        code_ok;

    // configuration register
    assign reg_idx = paddr[2];
    assign pready  = 1'b1;
    assign prdata  = (reg_idx == REG_VALUE_TYPE) ? 32'(r_vtype) : 32'd0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vtype <= VALUE_TYPE_RST;
        end else if (psel && penable && pwrite && pready && reg_idx == REG_VALUE_TYPE) begin
            r_vtype <= pwdata[2:0];
        end
    end

    // scanner
    assign p_move        = r_pv && (!r_ov || m_axis_tready);
    assign s_axis_tready = !r_pv || p_move;
    assign s_acc         = s_axis_tvalid && s_axis_tready;

    ilp_scan #(
        .MAX_LEN (MAX_LEN)
    ) u_scan (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_acc    (s_acc),
        .i_char   (s_axis_tdata),
        .i_last   (s_axis_tlast),
        .i_signed (r_vtype[0]),
        .o_res    (scan_res),
        .o_pend   (scan_pend)
    );

    // pending stage
    always_comb begin
        n_pv = r_pv;
        if (s_acc && scan_res) n_pv = 1'b1;
        else if (p_move)       n_pv = 1'b0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pv <= 1'b0;
        end else begin
            r_pv <= n_pv;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_acc && scan_res) r_pend <= scan_pend;
    end

    // range check, sign and width conversion
    always_comb begin
        unique case (r_vtype[2:1])
            2'd0:    mask = 64'h0000_0000_0000_00ff;
            2'd1:    mask = 64'h0000_0000_0000_ffff;
            2'd2:    mask = 64'h0000_0000_ffff_ffff;
            default: mask = 64'hffff_ffff_ffff_ffff;
        endcase
    end

    assign tmax      = r_vtype[0] ? (mask >> 1) : mask;
    assign range_bad = r_pend.chk && (r_pend.ovf || r_pend.mag > tmax);

    always_comb begin
        if (r_pend.fail || range_bad) begin
            n_value = '0;
            n_len   = '0;
            n_err   = r_pend.fail ? r_pend.err : ERR_RANGE;
        end else begin
            n_value = (r_pend.neg ? (64'd0 - r_pend.mag) : r_pend.mag) & mask;
            n_len   = r_pend.len;
            n_err   = ERR_OK;
        end
    end

    // output register
    always_comb begin
        n_ov = r_ov;
        if (p_move)             n_ov = 1'b1;
        else if (m_axis_tready) n_ov = 1'b0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else begin
            r_ov <= n_ov;
        end
    end

    always_ff @(posedge i_clk) begin
        if (p_move) begin
            r_value <= n_value;
            r_kind  <= r_pend.kind;
            r_len   <= n_len;
            r_err   <= n_err;
        end
    end

    assign m_axis_tvalid = r_ov;
    assign m_axis_tdata  = {(TDATA_W - 74)'(0), r_err, r_len, r_value};
    assign m_axis_tuser  = r_kind;

    assign err_clean = (r_err == ERR_OK) || (r_value == 64'd0 && r_len == 7'd0);
    assign code_ok   = (r_kind == KIND_DEC || r_kind == KIND_HEX || r_kind == KIND_OCT
                        || r_kind == KIND_BIN || r_kind == KIND_CHAR)
                       && (r_err == ERR_OK || r_err == ERR_INVALID || r_err == ERR_RANGE
                        || r_err == ERR_BADCHAR);

    `ILP_ASSERT(a_err_zero, r_ov |-> err_clean, "error result carries data")
    `ILP_ASSERT(a_no_overrun, (s_acc && scan_res) |-> (!r_pv || p_move), "pending overwritten")
    `ILP_ASSERT_NEXT(a_pend_hold, (r_pv && !p_move), r_pv, "pending result lost")
    `ILP_ASSERT(a_codes, r_ov |-> code_ok, "bad result code")

endmodule

/* tb/testbench.sv */
// Self-checking bench for integer_literal_parser_core: character stream in, literal results out.
// Needs ilp_pkg and the core RTL; predicts each result in a scanner of its own and
// compares it with what leaves m_axis, while value_type steps through all target types.
module testbench;
    import ilp_pkg::*;

    localparam int MAX_CHARS = 64;
    localparam int STALL_LIMIT = 500;
    localparam int PHASE_CHARS = 185;
    localparam logic [2:0] VALUE_TYPE_ADDR = {REG_VALUE_TYPE, 2'b00};

    localparam logic [2:0] TYPE_U8  = 3'd0;
    localparam logic [2:0] TYPE_S8  = 3'd1;
    localparam logic [2:0] TYPE_U16 = 3'd2;
    localparam logic [2:0] TYPE_S16 = 3'd3;
    localparam logic [2:0] TYPE_U32 = 3'd4;
    localparam logic [2:0] TYPE_S32 = 3'd5;
    localparam logic [2:0] TYPE_U64 = 3'd6;
    localparam logic [2:0] TYPE_S64 = 3'd7;
    localparam logic [23:0] TYPE_PLAN = {TYPE_S32, TYPE_U32, TYPE_S16, TYPE_U16,
                                         TYPE_U64, TYPE_S8, TYPE_S64, TYPE_U8};

    typedef enum logic [3:0] {
        SCAN_IDLE, SCAN_SIGN, SCAN_LEAD0, SCAN_PREFIX, SCAN_DIGITS,
        SCAN_QOPEN, SCAN_ESC, SCAN_HEXHI, SCAN_HEXLO, SCAN_QCLOSE
    } t_scan_phase;

    typedef struct packed {
        logic [63:0] val_bits;
        logic [2:0]  kind;
        logic [6:0]  len;
        logic [2:0]  err;
    } t_lit_result;

    typedef struct packed {
        logic [7:0] ch;
        logic       last;
        logic [2:0] gap;
    } t_char_req;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata = 8'd0;
    logic        s_axis_tlast = 1'b0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [TDATA_W-1:0] m_axis_tdata;
    logic [2:0]  m_axis_tuser;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [2:0]  paddr = 3'd0;
    logic [31:0] pwdata = 32'd0;
    logic [31:0] prdata;
    logic        pready;

    integer_literal_parser_core dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    // scanner state of the prediction
    t_scan_phase scan_ph;
    logic [63:0] acc_mag;
    logic        acc_ovf;
    logic        lit_neg;
    logic [2:0]  lit_kind;
    logic [6:0]  lit_len;
    logic [3:0]  esc_hi;
    logic        skip_rest;
    logic [2:0]  cfg_type;

    t_char_req   char_q[$];
    t_lit_result lit_expect_q[$];
    logic [7:0]  tok[$];

    t_char_req   drv_req;
    t_lit_result pred_res, seen_res, want_res;
    bit          s_fire, m_fire, out_calm;
    int          gap_cnt, stall_cnt, idle_cycles;
    int          pushed_cnt, taken_cnt, token_cnt, checked_cnt, miss_cnt, cfg_writes;

    function automatic string show_result(t_lit_result r);
        return $sformatf("value %h kind %0d len %0d err %0d", r.val_bits, r.kind, r.len, r.err);
    endfunction

    function automatic void note_miss(string msg);
        miss_cnt++;
        if (miss_cnt <= 10) $display("MISMATCH at %0t: %s", $time, msg);
    endfunction

    function automatic int radix_for(logic [2:0] k);
        case (k)
            KIND_HEX: return 16;
            KIND_OCT: return 8;
            KIND_BIN: return 2;
            default:  return 10;
        endcase
    endfunction

    function automatic int digit_in(logic [7:0] c, int radix);
        int d;
        d = -1;
        if (c >= CH_0 && c <= CH_9) d = int'(c) - int'(CH_0);
        else if (c >= CH_LA && c <= CH_LF) d = int'(c) - int'(CH_LA) + 10;
        else if (c >= CH_UA && c <= CH_UF) d = int'(c) - int'(CH_UA) + 10;
        if (d >= radix) d = -1;
        return d;
    endfunction

    function automatic int esc_code(logic [7:0] c);
        case (c)
            CH_BSLASH: return CH_BSLASH;
            CH_QUOTE:  return CH_QUOTE;
            "a":       return 7;
            "b":       return 8;
            "f":       return 12;
            "n":       return 10;
            "r":       return 13;
            "t":       return 9;
            "v":       return 11;
            CH_QMARK:  return CH_QMARK;
            CH_DQUOTE: return CH_DQUOTE;
            default:   return -1;
        endcase
    endfunction

    function automatic void clear_scan();
        scan_ph = SCAN_IDLE;
        acc_mag = 64'd0;
        acc_ovf = 1'b0;
        lit_neg = 1'b0;
        lit_kind = KIND_DEC;
        lit_len = 7'd0;
        esc_hi = 4'd0;
    endfunction

    function automatic void count_char();
        if (lit_len < MAX_CHARS) lit_len++;
    endfunction

    function automatic t_lit_result refuse(logic [2:0] e);
        t_lit_result r;
        r.val_bits = 64'd0;
        r.kind = lit_kind;
        r.len = 7'd0;
        r.err = e;
        return r;
    endfunction

    function automatic t_lit_result close_value(bit check);
        t_lit_result r;
        logic [63:0] mask, top;
        mask = 64'hFFFF_FFFF_FFFF_FFFF >> (64 - (8 << cfg_type[2:1]));
        top = cfg_type[0] ? (mask >> 1) : mask;
        if (check && (acc_ovf || acc_mag > top)) return refuse(ERR_RANGE);
        r.val_bits = (lit_neg ? 64'd0 - acc_mag : acc_mag) & mask;
        r.kind = lit_kind;
        r.len = lit_len;
        r.err = ERR_OK;
        return r;
    endfunction

    function automatic void take_digit(int d);
        logic [63:0] base, dd;
        base = 64'(radix_for(lit_kind));
        dd = 64'(d);
        if (acc_ovf) return;
        if (acc_mag > (64'hFFFF_FFFF_FFFF_FFFF - dd) / base) acc_ovf = 1'b1;
        else acc_mag = acc_mag * base + dd;
    endfunction

    function automatic bit open_body(logic [7:0] c, output t_lit_result r);
        r = '0;
        if (c == CH_QUOTE) begin
            lit_kind = KIND_CHAR;
            count_char();
            scan_ph = SCAN_QOPEN;
            return 1'b0;
        end
        if (c == CH_0) begin
            count_char();
            scan_ph = SCAN_LEAD0;
            return 1'b0;
        end
        if (c >= CH_1 && c <= CH_9) begin
            lit_kind = KIND_DEC;
            acc_mag = 64'(c - CH_0);
            count_char();
            scan_ph = SCAN_DIGITS;
            return 1'b0;
        end
        r = refuse(ERR_INVALID);
        return 1'b1;
    endfunction

    function automatic bit digit_run(logic [7:0] c, output t_lit_result r);
        int d;
        r = '0;
        d = digit_in(c, radix_for(lit_kind));
        scan_ph = SCAN_DIGITS;
        if (d >= 0) begin
            take_digit(d);
            count_char();
            return 1'b0;
        end
        if (c == CH_UNDER) begin
            count_char();
            return 1'b0;
        end
        r = close_value(1'b1);
        return 1'b1;
    endfunction

    function automatic bit scan_feed(logic [7:0] c, output t_lit_result r);
        int d;
        r = '0;
        case (scan_ph)
            SCAN_IDLE: begin
                if (c == CH_PLUS || c == CH_MINUS) begin
                    if (c == CH_MINUS) begin
                        if (!cfg_type[0]) begin
                            r = refuse(ERR_RANGE);
                            return 1'b1;
                        end
                        lit_neg = 1'b1;
                    end
                    count_char();
                    scan_ph = SCAN_SIGN;
                    return 1'b0;
                end
                return open_body(c, r);
            end
            SCAN_SIGN: return open_body(c, r);
            SCAN_LEAD0: begin
                if (c == CH_LX || c == CH_UX) lit_kind = KIND_HEX;
                else if (c == CH_LO || c == CH_UO) lit_kind = KIND_OCT;
                else if (c == CH_LB || c == CH_UB) lit_kind = KIND_BIN;
                else begin
                    lit_kind = KIND_DEC;
                    return digit_run(c, r);
                end
                count_char();
                scan_ph = SCAN_PREFIX;
                return 1'b0;
            end
            SCAN_PREFIX: begin
                d = digit_in(c, radix_for(lit_kind));
                if (d < 0) begin
                    r = refuse(ERR_INVALID);
                    return 1'b1;
                end
                take_digit(d);
                count_char();
                scan_ph = SCAN_DIGITS;
                return 1'b0;
            end
            SCAN_DIGITS: return digit_run(c, r);
            SCAN_QOPEN: begin
                if (c >= CH_PRT_LO && c <= CH_PRT_HI && c != CH_QUOTE && c != CH_BSLASH) begin
                    acc_mag = 64'(c);
                    count_char();
                    scan_ph = SCAN_QCLOSE;
                    return 1'b0;
                end
                if (c == CH_BSLASH) begin
                    count_char();
                    scan_ph = SCAN_ESC;
                    return 1'b0;
                end
                r = refuse(ERR_BADCHAR);
                return 1'b1;
            end
            SCAN_ESC: begin
                if (c == CH_LX) begin
                    count_char();
                    scan_ph = SCAN_HEXHI;
                    return 1'b0;
                end
                d = esc_code(c);
                if (d < 0) begin
                    r = refuse(ERR_BADCHAR);
                    return 1'b1;
                end
                acc_mag = 64'(d);
                count_char();
                scan_ph = SCAN_QCLOSE;
                return 1'b0;
            end
            SCAN_HEXHI, SCAN_HEXLO: begin
                d = digit_in(c, 16);
                if (d < 0) begin
                    r = refuse(ERR_BADCHAR);
                    return 1'b1;
                end
                count_char();
                if (scan_ph == SCAN_HEXHI) begin
                    esc_hi = 4'(d);
                    scan_ph = SCAN_HEXLO;
                end else begin
                    acc_mag = {56'd0, esc_hi, 4'(d)};
                    scan_ph = SCAN_QCLOSE;
                end
                return 1'b0;
            end
            default: begin
                if (c != CH_QUOTE) begin
                    r = refuse(ERR_BADCHAR);
                    return 1'b1;
                end
                count_char();
                r = close_value(1'b0);
                return 1'b1;
            end
        endcase
    endfunction

    function automatic t_lit_result token_end();
        case (scan_ph)
            SCAN_LEAD0: begin
                lit_kind = KIND_DEC;
                return close_value(1'b1);
            end
            SCAN_DIGITS: return close_value(1'b1);
            SCAN_QOPEN, SCAN_ESC, SCAN_HEXHI, SCAN_HEXLO, SCAN_QCLOSE: return refuse(ERR_BADCHAR);
            default: return refuse(ERR_INVALID);
        endcase
    endfunction

    function automatic bit predict_literal(logic [7:0] c, logic last, output t_lit_result r);
        bit got;
        r = '0;
        if (skip_rest) begin
            if (last) begin
                skip_rest = 1'b0;
                clear_scan();
            end
            return 1'b0;
        end
        got = scan_feed(c, r);
        if (!got && last) begin
            r = token_end();
            got = 1'b1;
        end
        if (got) begin
            clear_scan();
            skip_rest = !last;
        end
        return got;
    endfunction

    function automatic logic [63:0] pick_mag();
        logic [63:0] half;
        half = 64'd1 << (8 * (1 << $urandom_range(0, 3)) - 1);
        case ($urandom_range(0, 5))
            0: return 64'($urandom_range(0, 300));
            1: return {$urandom, $urandom} >> $urandom_range(0, 63);
            2: return half - 64'd1;
            3: return half;
            4: return (half << 1) - 64'd1;
            default: return half << 1;
        endcase
    endfunction

    function automatic void add_text(string s);
        for (int i = 0; i < s.len(); i++) tok.push_back(s[i]);
    endfunction

    task automatic make_token();
        string digs, specials, esc_chars;
        int shape, k, p;
        specials = "+-0'\\_xXoObB19aF";
        esc_chars = "\\'abfnrtv?\"";
        tok.delete();
        shape = $urandom_range(0, 99);
        if (shape < 78 && $urandom_range(0, 3) == 0)
            tok.push_back(($urandom_range(0, 1) != 0) ? CH_MINUS : CH_PLUS);
        if (shape < 55) begin
            k = (shape < 28) ? 0 : $urandom_range(1, 3);
            case (k)
                0: digs = $sformatf("%0d", pick_mag());
                1: digs = $sformatf("%0h", pick_mag());
                2: digs = $sformatf("%0o", pick_mag());
                default: digs = $sformatf("%0b", pick_mag() >> $urandom_range(0, 56));
            endcase
            if ($urandom_range(0, 5) == 0) repeat ($urandom_range(1, 3)) digs = {digs, "1"};
            repeat ($urandom_range(0, 2)) begin
                p = $urandom_range(1, digs.len());
                digs = {digs.substr(0, p - 1), "_", digs.substr(p, digs.len() - 1)};
            end
            if (k != 0) begin
                if ($urandom_range(0, 19) == 0) digs = {"_", digs};
                tok.push_back(CH_0);
                case (k)
                    1: tok.push_back(($urandom_range(0, 1) != 0) ? CH_LX : CH_UX);
                    2: tok.push_back(($urandom_range(0, 1) != 0) ? CH_LO : CH_UO);
                    default: tok.push_back(($urandom_range(0, 1) != 0) ? CH_LB : CH_UB);
                endcase
                if ($urandom_range(0, 1) != 0) digs = digs.toupper();
            end
            add_text(digs);
        end else if (shape < 72) begin
            tok.push_back(CH_QUOTE);
            case ($urandom_range(0, 3))
                0, 1: tok.push_back(8'($urandom_range(CH_PRT_LO, CH_PRT_HI)));
                2: begin
                    tok.push_back(CH_BSLASH);
                    tok.push_back(esc_chars[$urandom_range(0, esc_chars.len() - 1)]);
                end
                default: begin
                    digs = $sformatf("%h", 8'($urandom_range(0, 255)));
                    if ($urandom_range(0, 1) != 0) digs = digs.toupper();
                    tok.push_back(CH_BSLASH);
                    tok.push_back(CH_LX);
                    add_text(digs);
                end
            endcase
            tok.push_back(CH_QUOTE);
        end else if (shape < 78) begin
            tok.push_back(CH_0);
            repeat ($urandom_range(60, 75))
                tok.push_back(($urandom_range(0, 3) == 0) ? CH_UNDER : CH_0);
            tok.push_back(CH_1);
        end else begin
            repeat ($urandom_range(1, 5))
                tok.push_back(($urandom_range(0, 1) != 0) ? 8'($urandom_range(0, 255))
                              : specials[$urandom_range(0, specials.len() - 1)]);
        end
        if (shape < 78 && $urandom_range(0, 9) == 0 && tok.size() > 1) begin
            if ($urandom_range(0, 1) != 0) begin
                k = $urandom_range(1, tok.size() - 1);
                while (tok.size() > k) void'(tok.pop_back());
            end else begin
                tok[$urandom_range(0, tok.size() - 1)] = 8'($urandom_range(0, 255));
            end
        end
        if ($urandom_range(0, 3) == 0)
            repeat ($urandom_range(1, 3))
                tok.push_back(($urandom_range(0, 1) != 0) ? 8'($urandom_range(0, 255))
                              : specials[$urandom_range(0, specials.len() - 1)]);
    endtask

    task automatic queue_token(input bit calm);
        t_char_req rq;
        bit rush;
        rush = calm || ($urandom_range(0, 3) == 0);
        foreach (tok[i]) begin
            rq.ch = tok[i];
            rq.last = (i == tok.size() - 1);
            rq.gap = rush ? 3'd0 : 3'($urandom_range(0, 7));
            char_q.push_back(rq);
        end
        pushed_cnt += tok.size();
        token_cnt++;
    endtask

    task automatic send_text(input string s);
        tok.delete();
        add_text(s);
        queue_token(1'b0);
    endtask

    task automatic settle(input int tail);
        while (char_q.size() != 0 || taken_cnt != pushed_cnt || lit_expect_q.size() != 0)
            @(posedge i_clk);
        repeat (tail) @(posedge i_clk);
    endtask

    task automatic write_value_type(input logic [2:0] vt);
        @(negedge i_clk);
        psel = 1'b1;
        penable = 1'b0;
        pwrite = 1'b1;
        paddr = VALUE_TYPE_ADDR;
        pwdata = 32'(vt);
        @(negedge i_clk);
        penable = 1'b1;
        do @(posedge i_clk); while (!pready);
        cfg_type = vt;
        cfg_writes++;
        @(negedge i_clk);
        penable = 1'b0;
        pwrite = 1'b0;
        @(negedge i_clk);
        penable = 1'b1;
        do @(posedge i_clk); while (!pready);
        if (prdata !== 32'(vt))
            note_miss($sformatf("value_type read back %h, wrote %0d", prdata, vt));
        @(negedge i_clk);
        psel = 1'b0;
        penable = 1'b0;
    endtask

    initial begin
        forever #2 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        s_fire = i_rst_n && s_axis_tvalid && s_axis_tready;
        if (s_fire) begin
            taken_cnt++;
            if (predict_literal(s_axis_tdata, s_axis_tlast, pred_res))
                lit_expect_q.push_back(pred_res);
        end
    end

    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
        end else if (!s_axis_tvalid || s_fire) begin
            if (char_q.size() != 0 && gap_cnt >= char_q[0].gap) begin
                drv_req = char_q.pop_front();
                s_axis_tvalid <= 1'b1;
                s_axis_tdata <= drv_req.ch;
                s_axis_tlast <= drv_req.last;
                gap_cnt = 0;
            end else begin
                s_axis_tvalid <= 1'b0;
                if (char_q.size() != 0) gap_cnt++;
            end
        end
    end

    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
        end else begin
            if (m_fire)
                stall_cnt = (out_calm || $urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 7);
            if (stall_cnt > 0) begin
                m_axis_tready <= 1'b0;
                stall_cnt--;
            end else begin
                m_axis_tready <= 1'b1;
            end
        end
    end

    always @(posedge i_clk) begin
        m_fire = i_rst_n && m_axis_tvalid && m_axis_tready;
        if (m_fire) begin
            seen_res.val_bits = m_axis_tdata[63:0];
            seen_res.len = m_axis_tdata[70:64];
            seen_res.err = m_axis_tdata[73:71];
            seen_res.kind = m_axis_tuser;
            if (lit_expect_q.size() == 0) begin
                note_miss({"result with nothing pending: ", show_result(seen_res)});
            end else begin
                want_res = lit_expect_q.pop_front();
                checked_cnt++;
                if (seen_res.val_bits !== want_res.val_bits || seen_res.kind !== want_res.kind ||
                    seen_res.len !== want_res.len || seen_res.err !== want_res.err)
                    note_miss({"expected ", show_result(want_res),
                               " / got ", show_result(seen_res)});
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) || psel)
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= STALL_LIMIT) begin
            $display("No transfer for %0d cycles, %0d results outstanding",
                     idle_cycles, lit_expect_q.size());
            $display("TB_ERROR");
            $finish;
        end
    end

    initial begin
        cfg_type = VALUE_TYPE_RST;
        clear_scan();
        skip_rest = 1'b0;
        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        send_text("0");
        send_text("-7");
        send_text("0x1F");
        send_text("0b");
        send_text("_");
        send_text("'\\''");
        send_text("'\\x");
        send_text("9z?");

        for (int p = 0; p < 10; p++) begin
            settle(8);
            write_value_type((p < 8) ? TYPE_PLAN[p * 3 +: 3] : 3'($urandom_range(0, 7)));
            out_calm = (p % 4 == 3);
            for (int n = pushed_cnt + PHASE_CHARS; pushed_cnt < n; ) begin
                make_token();
                queue_token(out_calm);
            end
        end
        settle(12);

        $display("Parsed %0d characters in %0d tokens under %0d value_type writes",
                 taken_cnt, token_cnt, cfg_writes);
        $display("Compared %0d results, %0d mismatches", checked_cnt, miss_cnt);
        if (miss_cnt == 0 && lit_expect_q.size() == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule

/* filelist.f */
+incdir+rtl
rtl/ilp_pkg.sv
rtl/ilp_scan.sv
rtl/integer_literal_parser_core.sv
tb/testbench.sv
